// ----- design/mkp_pkg.sv -----
`default_nettype none

package mkp_pkg;

	localparam int LEVEL_W      = 4;
	localparam int TICK_IN_W    = 16;
	localparam int DEBOUNCE_W   = 16;
	localparam int KEY_CODE_W   = 7;
	localparam int ROW_OUT_W    = 2;
	localparam int RESULT_LIMIT = 4;
	localparam int MAP_IDX_W    = 3;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_CONFIRM = 2'd1,
		PH_RELEASE = 2'd2
	} phase_t;

	// Key map, row by row: "123A", "456B", "789C", "*0#D".
	localparam logic [KEY_CODE_W-1:0] KEY_MAP [0:15] = '{
		7'h31, 7'h32, 7'h33, 7'h41,
		7'h34, 7'h35, 7'h36, 7'h42,
		7'h37, 7'h38, 7'h39, 7'h43,
		7'h2A, 7'h30, 7'h23, 7'h44
	};

	function automatic logic [KEY_CODE_W-1:0] key_code_of(
		input logic [MAP_IDX_W-1:0] row,
		input logic [MAP_IDX_W-1:0] col
	);
		logic [KEY_CODE_W-1:0] code;
		code = '0;
		if (row < 3'd4 && col < 3'd4) begin
			code = KEY_MAP[{row[1:0], col[1:0]}];
		end
		return code;
	endfunction

endpackage

`default_nettype wire

// ----- design/mkp_lane.sv -----
`default_nettype none

module mkp_lane
	import mkp_pkg::*;
#(
	parameter int ROW_COUNT  = 4,
	parameter int TICK_WIDTH = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          step,
	input  wire logic [((ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1)-1:0] row,
	input  wire logic                                          low,
	input  wire logic [TICK_WIDTH-1:0]                         now,
	input  wire logic [DEBOUNCE_W-1:0]                         debounce,
	output logic                                               confirm
);

	localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int CMP_W = (TICK_WIDTH > DEBOUNCE_W) ? TICK_WIDTH : DEBOUNCE_W;

	phase_t                phase_q [ROW_COUNT];
	logic [TICK_WIDTH-1:0] time_q  [ROW_COUNT];

	phase_t                phase_cur;
	phase_t                phase_nxt;
	logic [TICK_WIDTH-1:0] elapsed;
	logic                  expired;
	logic                  time_wr;

	assign phase_cur = phase_q[row];
	assign elapsed   = now - time_q[row];
	assign expired   = CMP_W'(elapsed) > CMP_W'(debounce);

	always_comb begin
		phase_nxt = phase_cur;
		confirm   = 1'b0;
		time_wr   = 1'b0;
		case (phase_cur)
			PH_CONFIRM: begin
				if (expired) begin
					confirm   = low;
					phase_nxt = low ? PH_RELEASE : PH_IDLE;
				end
			end
			PH_RELEASE: begin
				if (!low) begin
					phase_nxt = PH_IDLE;
				end
			end
			default: begin
				if (low) begin
					phase_nxt = PH_CONFIRM;
					time_wr   = 1'b1;
				end else begin
					phase_nxt = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROW_COUNT; r++) begin
				phase_q[r] <= PH_IDLE;
			end
		end else if (step) begin
			phase_q[row] <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step && time_wr) begin
			time_q[row] <= now;
		end
	end

endmodule

`default_nettype wire

// ----- design/mkp_merge.sv -----
`default_nettype none

module mkp_merge
	import mkp_pkg::*;
#(
	parameter int ROW_COUNT    = 4,
	parameter int COLUMN_COUNT = 4
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          load,
	output logic                                               load_ready,
	input  wire logic [COLUMN_COUNT-1:0]                       found,
	input  wire logic [((ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1)-1:0] row,
	input  wire logic [ROW_OUT_W-1:0]                          next,
	output logic                                               out_valid,
	input  wire logic                                          out_ready,
	output logic                                               key_valid,
	output logic [KEY_CODE_W-1:0]                              key_code,
	output logic [ROW_OUT_W-1:0]                               next_row,
	output logic                                               last_result
);

	localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int COL_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
	localparam int CNT_W = $clog2(COLUMN_COUNT + 1) + 1;

	logic                    pend_valid_s1;
	logic [COLUMN_COUNT-1:0] pend_mask_s1;
	logic [ROW_W-1:0]        pend_row_s1;
	logic [ROW_OUT_W-1:0]    pend_next_s1;

	logic                    out_valid_s2;
	logic                    key_valid_s2;
	logic [KEY_CODE_W-1:0]   key_code_s2;
	logic [ROW_OUT_W-1:0]    next_row_s2;
	logic                    last_s2;

	logic [COLUMN_COUNT-1:0] kept;
	logic [CNT_W-1:0]        kept_cnt;
	logic [COL_W-1:0]        sel;
	logic [COLUMN_COUNT-1:0] rest;
	logic                    out_free;
	logic                    emit;
	logic                    done;
	logic [KEY_CODE_W-1:0]   sel_code;

	// Only the first confirmed keys of a row, in column order, are reported.
	always_comb begin
		kept     = '0;
		kept_cnt = '0;
		for (int c = 0; c < COLUMN_COUNT; c++) begin
			if (found[c] && kept_cnt < CNT_W'(RESULT_LIMIT)) begin
				kept[c]  = 1'b1;
				kept_cnt = kept_cnt + CNT_W'(1);
			end
		end
	end

	always_comb begin
		sel = '0;
		for (int c = COLUMN_COUNT - 1; c >= 0; c--) begin
			if (pend_mask_s1[c]) begin
				sel = COL_W'(c);
			end
		end
	end

	assign rest       = pend_mask_s1 & (pend_mask_s1 - COLUMN_COUNT'(1));
	assign sel_code   = key_code_of(MAP_IDX_W'(pend_row_s1), MAP_IDX_W'(sel));
	assign out_free   = !out_valid_s2 || out_ready;
	assign emit       = pend_valid_s1 && out_free;
	assign done       = emit && (rest == '0);
	assign load_ready = !pend_valid_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_s1 <= 1'b0;
			out_valid_s2  <= 1'b0;
		end else begin
			if (load) begin
				pend_valid_s1 <= 1'b1;
			end else if (done) begin
				pend_valid_s1 <= 1'b0;
			end
			if (emit) begin
				out_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pend_mask_s1 <= kept;
			pend_row_s1  <= row;
			pend_next_s1 <= next;
		end else if (emit) begin
			pend_mask_s1 <= rest;
		end
		if (emit) begin
			key_valid_s2 <= (pend_mask_s1 != '0);
			key_code_s2  <= (pend_mask_s1 != '0) ? sel_code : '0;
			next_row_s2  <= pend_next_s1;
			last_s2      <= (rest == '0);
		end
	end

	assign out_valid   = out_valid_s2;
	assign key_valid   = key_valid_s2;
	assign key_code    = key_code_s2;
	assign next_row    = next_row_s2;
	assign last_result = last_s2;

`ifndef SYNTHESIS
	a_pend_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_s1 |-> $countones(pend_mask_s1) <= RESULT_LIMIT)
		else $error("more pending keys than results allowed");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !key_valid_s2 |-> last_s2 && key_code_s2 == '0)
		else $error("empty result not final or carries a code");

	a_continue: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !done |=> pend_valid_s1)
		else $error("row dropped before its last result");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> load_ready)
		else $error("row loaded while previous row still pending");
`endif

endmodule

`default_nettype wire

// ----- design/matrix_keypad_scan_debounce.sv -----
// Key matrix scanner with per-key debounce. Each input item carries the column levels of the
// row named by the previous result's next_row (row 0 after reset) and the current tick. One
// lane per column keeps the phase and press time of every key in that column and updates the
// scanned row in the cycle the item is accepted. A row that confirms no key yields one result
// with key_valid low; a row that confirms k keys yields k results in column order, at most
// four, the final one with last_result set. The single output register takes one result per
// cycle unless out_ready stalls it; one-result rows stream at one item per cycle. The debounce
// threshold resets to 20; the user must write it through cfg_wr_en and cfg_wr_data while the
// block is idle, which the block itself does not enforce.
`default_nettype none

module matrix_keypad_scan_debounce
	import mkp_pkg::*;
#(
	parameter int ROW_COUNT    = 4,
	parameter int COLUMN_COUNT = 4,
	parameter int TICK_WIDTH   = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [DEBOUNCE_W-1:0] cfg_wr_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [LEVEL_W-1:0]    column_levels,
	input  wire logic [TICK_IN_W-1:0]  now_tick,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       key_valid,
	output logic [KEY_CODE_W-1:0]      key_code,
	output logic [ROW_OUT_W-1:0]       next_row,
	output logic                       last_result
);

	localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	logic [DEBOUNCE_W-1:0]   debounce_q;
	logic [ROW_W-1:0]        row_q;
	logic [ROW_W-1:0]        row_nxt;
	logic                    accept;
	logic [TICK_WIDTH-1:0]   now;
	logic [COLUMN_COUNT-1:0] low;
	logic [COLUMN_COUNT-1:0] found;

	assign accept  = in_valid && in_ready;
	assign now     = TICK_WIDTH'(now_tick);
	assign row_nxt = (row_q == ROW_W'(ROW_COUNT - 1)) ? '0 : row_q + ROW_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			row_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				debounce_q <= cfg_wr_data;
			end
			if (accept) begin
				row_q <= row_nxt;
			end
		end
	end

	for (genvar c = 0; c < COLUMN_COUNT; c++) begin : g_lane
		if (c < LEVEL_W) begin : g_pin
			assign low[c] = !column_levels[c];
		end else begin : g_none
			assign low[c] = 1'b0;
		end

		mkp_lane #(
			.ROW_COUNT  (ROW_COUNT),
			.TICK_WIDTH (TICK_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (accept),
			.row      (row_q),
			.low      (low[c]),
			.now      (now),
			.debounce (debounce_q),
			.confirm  (found[c])
		);
	end

	mkp_merge #(
		.ROW_COUNT    (ROW_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.load_ready  (in_ready),
		.found       (found),
		.row         (row_q),
		.next        (ROW_OUT_W'(row_nxt)),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_valid   (key_valid),
		.key_code    (key_code),
		.next_row    (next_row),
		.last_result (last_result)
	);

endmodule

`default_nettype wire
